/* design/crc8_frame_deframer_macros.svh */
// Assertion macros for the CRC-8 frame deframer.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef CRC8_FRAME_DEFRAMER_MACROS_SVH
`define CRC8_FRAME_DEFRAMER_MACROS_SVH

// Checked only while out of reset.
`define CRC8FD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define CRC8FD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* design/crc8fd_pkg.sv */
// Shared types, constants and the CRC-8 byte step for the frame deframer.
// No dependencies.
`default_nettype none

package crc8fd_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 32;
  localparam int unsigned DATA_W          = 8;
  localparam int unsigned IDX_W           = 5;
  localparam int unsigned LEN_W           = 6;
  localparam int unsigned OUT_TDATA_W     = 24;
  localparam int unsigned CFG_IDX_W       = 1;
  localparam int unsigned CFG_DATA_W      = 8;

  localparam logic [DATA_W-1:0] HEADER_RST = 8'hAA;
  localparam logic [LEN_W-1:0]  MAXLEN_RST = 6'd32;
  localparam logic [DATA_W-1:0] CRC_POLY   = 8'h8C;

  localparam logic [CFG_IDX_W-1:0] REG_HEADER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAXLEN = 1'b1;

  typedef enum logic [4:0] {
    ST_HEADER  = 5'b00001,
    ST_LENGTH  = 5'b00010,
    ST_PAYLOAD = 5'b00100,
    ST_CRC     = 5'b01000,
    ST_READ    = 5'b10000
  } state_e;

  // Reflected CRC-8 over one byte, start value taken from crc.
  function automatic logic [DATA_W-1:0] crc8_step(input logic [DATA_W-1:0] crc,
                                                  input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* design/crc8fd_store.sv */
// Payload buffer: one write port and one read port with registered read data.
// Uses crc8fd_pkg for the data width.
`default_nettype none

module crc8fd_store #(
  parameter int unsigned DEPTH = crc8fd_pkg::MAX_PAYLOAD_DEF,
  parameter int unsigned AW    = 5
) (
  input  wire logic                          clk_i,
  input  wire logic                          wr_en_i,
  input  wire logic [AW-1:0]                 wr_addr_i,
  input  wire logic [crc8fd_pkg::DATA_W-1:0] wr_data_i,
  input  wire logic                          rd_en_i,
  input  wire logic [AW-1:0]                 rd_addr_i,
  output logic      [crc8fd_pkg::DATA_W-1:0] rd_data_o
);
  import crc8fd_pkg::*;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

/* design/crc8_frame_deframer.sv */
// Channel    Dir  Payload (tdata low bit up)                     Marker
// s_axis     in   data_byte[7:0]                                 -
// m_axis     out  payload_byte[7:0] byte_index[12:8]             tlast = last
//                 frame_length[18:13] zero[23:19]
// cfg        in   cfg_idx_i 0 header_byte, 1 max_length          -
//
// One received byte is taken per cycle while a frame is being parsed.
// A verified frame of length L is read back from the payload buffer one
// result at a time (registered read, then output register), a read issued
// once the previous lands; input is held off until the final result is read.
// The output register holds a result under back-pressure without losing it.
// Reset is asynchronous, active low; the buffer needs no clearing pass.
// Depends on crc8fd_pkg, crc8fd_store and crc8_frame_deframer_macros.svh.
`default_nettype none
`include "crc8_frame_deframer_macros.svh"

module crc8_frame_deframer #(
  parameter int unsigned MAX_PAYLOAD = crc8fd_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // tdata: data_byte[7:0]
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [crc8fd_pkg::DATA_W-1:0]      s_axis_tdata,
  // tdata: payload_byte[7:0], byte_index[12:8], frame_length[18:13], zeros
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic      [crc8fd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                                    m_axis_tlast,
  input  wire logic                               cfg_we_i,
  input  wire logic [crc8fd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [crc8fd_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import crc8fd_pkg::*;

  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  state_e             state_q, state_d;
  logic [DATA_W-1:0]  hdr_q;
  logic [LEN_W-1:0]   maxlen_q;
  logic [LEN_W-1:0]   exp_q, exp_d;
  logic [LEN_W-1:0]   fill_q, fill_d;
  logic [LEN_W-1:0]   rd_cnt_q, rd_cnt_d;
  logic [DATA_W-1:0]  crc_q, crc_d;
  logic               pend_q, pend_d;
  logic [IDX_W-1:0]   pend_idx_q, pend_idx_d;
  logic               pend_last_q, pend_last_d;
  logic [LEN_W-1:0]   pend_len_q, pend_len_d;
  logic               out_valid_q, out_valid_d;
  logic [DATA_W-1:0]  out_byte_q;
  logic [IDX_W-1:0]   out_idx_q;
  logic [LEN_W-1:0]   out_len_q;
  logic               out_last_q;

  logic               in_acc;
  logic [LEN_W-1:0]   limit;
  logic [LEN_W-1:0]   fill_inc;
  logic [LEN_W-1:0]   rd_inc;
  logic               wr_en;
  logic               rd_en;
  logic [DATA_W-1:0]  rd_data;

  assign s_axis_tready = (state_q != ST_READ);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign fill_inc      = fill_q + 6'd1;
  assign rd_inc        = rd_cnt_q + 6'd1;

  // Effective length limit is the smaller of the register and the buffer size.
  assign limit = ({1'b0, maxlen_q} > 7'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD) : maxlen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q    <= HEADER_RST;
      maxlen_q <= MAXLEN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_HEADER: hdr_q    <= cfg_data_i;
        REG_MAXLEN: maxlen_q <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    exp_d       = exp_q;
    fill_d      = fill_q;
    crc_d       = crc_q;
    rd_cnt_d    = rd_cnt_q;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    pend_idx_d  = pend_idx_q;
    pend_last_d = pend_last_q;
    pend_len_d  = pend_len_q;
    case (state_q)
      ST_HEADER: begin
        if (in_acc && (s_axis_tdata == hdr_q)) begin
          crc_d   = '0;
          state_d = ST_LENGTH;
        end
      end
      ST_LENGTH: begin
        if (in_acc) begin
          if ((s_axis_tdata == '0) || (s_axis_tdata > {2'b00, limit})) begin
            state_d = ST_HEADER;
          end else begin
            exp_d   = s_axis_tdata[LEN_W-1:0];
            fill_d  = '0;
            crc_d   = crc8_step(crc_q, s_axis_tdata);
            state_d = ST_PAYLOAD;
          end
        end
      end
      ST_PAYLOAD: begin
        if (in_acc) begin
          wr_en  = 1'b1;
          fill_d = fill_inc;
          crc_d  = crc8_step(crc_q, s_axis_tdata);
          if (fill_inc >= exp_q) begin
            state_d = ST_CRC;
          end
        end
      end
      ST_CRC: begin
        if (in_acc) begin
          rd_cnt_d = '0;
          state_d  = (s_axis_tdata == crc_q) ? ST_READ : ST_HEADER;
        end
      end
      ST_READ: begin
        // Issue a read only when the output register will be free as the data lands.
        // All reads finish here before any new byte can be written, so the two
        // ports never touch the same entry in one cycle.
        if (!pend_q && (!out_valid_q || m_axis_tready)) begin
          rd_en       = 1'b1;
          pend_idx_d  = rd_cnt_q[IDX_W-1:0];
          pend_last_d = (rd_inc == exp_q);
          pend_len_d  = exp_q;
          rd_cnt_d    = rd_inc;
          if (rd_inc == exp_q) begin
            state_d = ST_HEADER;
          end
        end
      end
      default: state_d = ST_HEADER;
    endcase
  end

  assign pend_d      = rd_en;
  assign out_valid_d = pend_q | (out_valid_q & ~m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_HEADER;
      exp_q       <= '0;
      fill_q      <= '0;
      crc_q       <= '0;
      rd_cnt_q    <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      exp_q       <= exp_d;
      fill_q      <= fill_d;
      crc_q       <= crc_d;
      rd_cnt_q    <= rd_cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q  <= pend_idx_d;
    pend_last_q <= pend_last_d;
    pend_len_q  <= pend_len_d;
    if (pend_q) begin
      out_byte_q <= rd_data;
      out_idx_q  <= pend_idx_q;
      out_len_q  <= pend_len_q;
      out_last_q <= pend_last_q;
    end
  end

  crc8fd_store #(
    .DEPTH (MAX_PAYLOAD),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (fill_q[AW-1:0]),
    .wr_data_i (s_axis_tdata),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_cnt_q[AW-1:0]),
    .rd_data_o (rd_data)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {5'b00000, out_len_q, out_idx_q, out_byte_q};

  // A pending read must find the output register free or draining.
  `CRC8FD_ASSERT(a_pend_slot_free, pend_q |-> (!out_valid_q || m_axis_tready), "read data would overwrite a held result")
  // Every pending read shows up as a result in the next cycle.
  `CRC8FD_ASSERT(a_pend_lands, pend_q |=> m_axis_tvalid, "buffer read did not reach the output")
  // The final read of a frame is issued as the readout ends.
  `CRC8FD_ASSERT(a_last_after_read, (pend_q && pend_last_q) |-> (state_q != ST_READ), "last read while readout still running")
  // While filling, the count stays below the frame length.
  `CRC8FD_ASSERT(a_fill_bound, (state_q == ST_PAYLOAD) |-> (fill_q < exp_q), "payload fill count ran past the frame length")
  // No result is offered while reset is held.
  `CRC8FD_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> (!m_axis_tvalid && !pend_q), "result offered during reset")

endmodule

`default_nettype wire
